FILE: rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// shared constants for the column aggregate unit
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int COUNT_BITS  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// column type codes
	localparam logic [2:0] TYPE_TINY    = 3'd0;
	localparam logic [2:0] TYPE_SMALL   = 3'd1;
	localparam logic [2:0] TYPE_INT     = 3'd2;
	localparam logic [2:0] TYPE_BIG     = 3'd3;
	localparam logic [2:0] TYPE_DECIMAL = 3'd4;
	localparam logic [2:0] TYPE_UNSUPP  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_CONST_MODE    = 2'd0;
	localparam logic [1:0] CFG_CONST_VALUE   = 2'd1;
	localparam logic [1:0] CFG_COLUMN_SORTED = 2'd2;

endpackage

FILE: rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// row intake: type extension, running sum, counts, max, min and type error per group
// ----------------------------------------------------------------------------
module cau_front #(
	parameter int CNT_W = cau_pkg::COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [63:0]      value,
	input  logic [2:0]       col_type,
	input  logic             is_null,
	input  logic             last,
	input  logic             column_sorted,
	output logic             push,
	output logic [63:0]      grp_sum,
	output logic             grp_ovf,
	output logic [CNT_W-1:0] grp_nonnull,
	output logic [CNT_W-1:0] grp_rows,
	output logic [63:0]      grp_max,
	output logic [63:0]      grp_min,
	output logic             grp_err
);

	logic [63:0]      sum_q;
	logic             ovf_q;
	logic [CNT_W-1:0] nonnull_q;
	logic [CNT_W-1:0] rows_q;
	logic [63:0]      max_q;
	logic [63:0]      min_q;
	logic             first_q;
	logic             err_q;

	logic [63:0] ext;
	logic        supported;
	logic        usable;
	logic [63:0] sum_raw;
	logic        sat_hit;

	always_comb begin
		case (col_type)
			cau_pkg::TYPE_TINY:  ext = {56'd0, value[7:0]};
			cau_pkg::TYPE_SMALL: ext = {{48{value[15]}}, value[15:0]};
			cau_pkg::TYPE_INT:   ext = {{32{value[31]}}, value[31:0]};
			default:             ext = value;
		endcase
	end

	assign supported = col_type inside {cau_pkg::TYPE_TINY, cau_pkg::TYPE_SMALL,
		cau_pkg::TYPE_INT, cau_pkg::TYPE_BIG};
	assign usable    = supported && !is_null;
	assign sum_raw   = sum_q + ext;
	assign sat_hit   = usable && (sum_q[63] == ext[63]) && (sum_raw[63] != sum_q[63]);

	always_comb begin
		grp_sum = sum_q;
		if (usable) begin
			if (sat_hit) begin
				grp_sum = sum_q[63] ? cau_pkg::S64_MIN : cau_pkg::S64_MAX;
			end else begin
				grp_sum = sum_raw;
			end
		end
		grp_ovf     = ovf_q || sat_hit;
		grp_rows    = (&rows_q) ? rows_q : rows_q + 1'b1;
		grp_nonnull = (is_null || (&nonnull_q)) ? nonnull_q : nonnull_q + 1'b1;
		grp_err     = err_q || (col_type >= cau_pkg::TYPE_UNSUPP);
		grp_max     = max_q;
		grp_min     = min_q;
		if (column_sorted) begin
			if (first_q && usable) begin
				grp_min = ext;
			end
			if (last && usable) begin
				grp_max = ext;
			end
		end else if (usable) begin
			if ($signed(max_q) < $signed(ext)) begin
				grp_max = ext;
			end
			if ($signed(ext) < $signed(min_q)) begin
				grp_min = ext;
			end
		end
	end

	assign push = accept && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			nonnull_q <= '0;
			rows_q    <= '0;
			max_q     <= cau_pkg::S64_MIN;
			min_q     <= cau_pkg::S64_MAX;
			first_q   <= 1'b1;
			err_q     <= 1'b0;
		end else if (accept) begin
			if (last) begin
				sum_q     <= '0;
				ovf_q     <= 1'b0;
				nonnull_q <= '0;
				rows_q    <= '0;
				max_q     <= cau_pkg::S64_MIN;
				min_q     <= cau_pkg::S64_MAX;
				first_q   <= 1'b1;
				err_q     <= 1'b0;
			end else begin
				sum_q     <= grp_sum;
				ovf_q     <= grp_ovf;
				nonnull_q <= grp_nonnull;
				rows_q    <= grp_rows;
				max_q     <= grp_max;
				min_q     <= grp_min;
				first_q   <= 1'b0;
				err_q     <= grp_err;
			end
		end
	end

endmodule

FILE: rtl/core/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// short queue of finished group summaries between intake and result side
// ----------------------------------------------------------------------------
module cau_queue #(
	parameter int CNT_W = cau_pkg::COUNT_BITS,
	parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [63:0]      in_sum,
	input  logic             in_ovf,
	input  logic [CNT_W-1:0] in_nonnull,
	input  logic [CNT_W-1:0] in_rows,
	input  logic [63:0]      in_max,
	input  logic [63:0]      in_min,
	input  logic             in_err,
	input  logic             pop,
	output logic             not_empty,
	output logic             full,
	output logic [63:0]      out_sum,
	output logic             out_ovf,
	output logic [CNT_W-1:0] out_nonnull,
	output logic [CNT_W-1:0] out_rows,
	output logic [63:0]      out_max,
	output logic [63:0]      out_min,
	output logic             out_err
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	logic [63:0]      sum_mem     [DEPTH];
	logic             ovf_mem     [DEPTH];
	logic [CNT_W-1:0] nonnull_mem [DEPTH];
	logic [CNT_W-1:0] rows_mem    [DEPTH];
	logic [63:0]      max_mem     [DEPTH];
	logic [63:0]      min_mem     [DEPTH];
	logic             err_mem     [DEPTH];

	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] fill_q;

	assign not_empty = (fill_q != '0);
	assign full      = (fill_q == CNT_QW'(DEPTH));

	assign out_sum     = sum_mem[rd_ptr_q];
	assign out_ovf     = ovf_mem[rd_ptr_q];
	assign out_nonnull = nonnull_mem[rd_ptr_q];
	assign out_rows    = rows_mem[rd_ptr_q];
	assign out_max     = max_mem[rd_ptr_q];
	assign out_min     = min_mem[rd_ptr_q];
	assign out_err     = err_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			sum_mem[wr_ptr_q]     <= in_sum;
			ovf_mem[wr_ptr_q]     <= in_ovf;
			nonnull_mem[wr_ptr_q] <= in_nonnull;
			rows_mem[wr_ptr_q]    <= in_rows;
			max_mem[wr_ptr_q]     <= in_max;
			min_mem[wr_ptr_q]     <= in_min;
			err_mem[wr_ptr_q]     <= in_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// result side: bit-serial average divider and registered result beat
// ----------------------------------------------------------------------------
module cau_back #(
	parameter int CNT_W = cau_pkg::COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [63:0]      q_sum,
	input  logic             q_ovf,
	input  logic [CNT_W-1:0] q_nonnull,
	input  logic [CNT_W-1:0] q_rows,
	input  logic [63:0]      q_max,
	input  logic [63:0]      q_min,
	input  logic             q_err,
	input  logic             const_mode,
	input  logic [63:0]      const_value,
	output logic             pop,
	output logic             done,
	output logic [63:0]      sum_out,
	output logic             sum_overflow,
	output logic [31:0]      count_out,
	output logic [31:0]      row_total,
	output logic [63:0]      max_out,
	output logic [63:0]      min_out,
	output logic [63:0]      avg_out,
	output logic             type_error
);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t           state_q;
	logic [5:0]       step_q;
	logic [CNT_W-1:0] rem_q;
	logic [63:0]      quo_q;
	logic             neg_q;
	logic [63:0]      sum_q;
	logic             ovf_q;
	logic [CNT_W-1:0] nonnull_q;
	logic [CNT_W-1:0] rows_q;
	logic [63:0]      max_q;
	logic [63:0]      min_q;
	logic             err_q;

	logic [CNT_W:0] shifted;
	logic [CNT_W:0] diff;
	logic           fits;
	logic [63:0]    quo_n;

	assign pop     = (state_q == ST_IDLE) && q_valid;
	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, rows_q};
	assign fits    = (shifted >= {1'b0, rows_q});
	assign quo_n   = {quo_q[62:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			step_q       <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			neg_q        <= 1'b0;
			sum_q        <= '0;
			ovf_q        <= 1'b0;
			nonnull_q    <= '0;
			rows_q       <= '0;
			max_q        <= '0;
			min_q        <= '0;
			err_q        <= 1'b0;
			sum_out      <= '0;
			sum_overflow <= 1'b0;
			count_out    <= '0;
			row_total    <= '0;
			max_out      <= '0;
			min_out      <= '0;
			avg_out      <= '0;
			type_error   <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						sum_q     <= q_sum;
						ovf_q     <= q_ovf;
						nonnull_q <= q_nonnull;
						rows_q    <= q_rows;
						max_q     <= q_max;
						min_q     <= q_min;
						err_q     <= q_err;
						neg_q     <= q_sum[63];
						quo_q     <= q_sum[63] ? (64'd0 - q_sum) : q_sum;
						rem_q     <= '0;
						step_q    <= '1;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
					quo_q  <= quo_n;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q    <= ST_IDLE;
						done       <= 1'b1;
						row_total  <= 32'(rows_q);
						type_error <= err_q;
						if (const_mode) begin
							sum_out      <= const_value;
							sum_overflow <= 1'b0;
							count_out    <= 32'(rows_q);
							max_out      <= const_value;
							min_out      <= const_value;
							avg_out      <= const_value;
						end else begin
							sum_out      <= sum_q;
							sum_overflow <= ovf_q;
							count_out    <= 32'(nonnull_q);
							max_out      <= max_q;
							min_out      <= min_q;
							avg_out      <= neg_q ? (64'd0 - quo_n) : quo_n;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/column_aggregate_unit.sv
// ----------------------------------------------------------------------------
// column_aggregate_unit
// sum, count, max, min and average over a group of column values
// ----------------------------------------------------------------------------
// throughput: one row per cycle while busy is low; each group holds the divider for
//   its whole division, and busy rises while QUEUE_DEPTH finished groups wait for it
// result: done rises when the divider finishes the group of the last row, later
//   if earlier groups still wait in the queue; the receiver cannot stall
// reset: arst_n clears group state, queue, divider and config registers
// ----------------------------------------------------------------------------
module column_aggregate_unit #(
	parameter int COUNT_BITS  = cau_pkg::COUNT_BITS,
	parameter int QUEUE_DEPTH = cau_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	input  logic [2:0]  col_type,
	input  logic        is_null,
	input  logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [63:0] sum_out,
	output logic        sum_overflow,
	output logic [31:0] count_out,
	output logic [31:0] row_total,
	output logic [63:0] max_out,
	output logic [63:0] min_out,
	output logic [63:0] avg_out,
	output logic        type_error
);

	logic        const_mode_q;
	logic [63:0] const_value_q;
	logic        column_sorted_q;

	logic                  accept;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	logic                  q_full;
	logic [63:0]           f_sum;
	logic                  f_ovf;
	logic [COUNT_BITS-1:0] f_nonnull;
	logic [COUNT_BITS-1:0] f_rows;
	logic [63:0]           f_max;
	logic [63:0]           f_min;
	logic                  f_err;
	logic [63:0]           b_sum;
	logic                  b_ovf;
	logic [COUNT_BITS-1:0] b_nonnull;
	logic [COUNT_BITS-1:0] b_rows;
	logic [63:0]           b_max;
	logic [63:0]           b_min;
	logic                  b_err;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			const_mode_q    <= 1'b0;
			const_value_q   <= '0;
			column_sorted_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cau_pkg::CFG_CONST_MODE:    const_mode_q    <= cfg_data[0];
				cau_pkg::CFG_CONST_VALUE:   const_value_q   <= cfg_data;
				cau_pkg::CFG_COLUMN_SORTED: column_sorted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cau_front #(
		.CNT_W(COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.value        (value),
		.col_type     (col_type),
		.is_null      (is_null),
		.last         (last),
		.column_sorted(column_sorted_q),
		.push         (q_push),
		.grp_sum      (f_sum),
		.grp_ovf      (f_ovf),
		.grp_nonnull  (f_nonnull),
		.grp_rows     (f_rows),
		.grp_max      (f_max),
		.grp_min      (f_min),
		.grp_err      (f_err)
	);

	cau_queue #(
		.CNT_W(COUNT_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.in_sum     (f_sum),
		.in_ovf     (f_ovf),
		.in_nonnull (f_nonnull),
		.in_rows    (f_rows),
		.in_max     (f_max),
		.in_min     (f_min),
		.in_err     (f_err),
		.pop        (q_pop),
		.not_empty  (q_valid),
		.full       (q_full),
		.out_sum    (b_sum),
		.out_ovf    (b_ovf),
		.out_nonnull(b_nonnull),
		.out_rows   (b_rows),
		.out_max    (b_max),
		.out_min    (b_min),
		.out_err    (b_err)
	);

	cau_back #(
		.CNT_W(COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_sum       (b_sum),
		.q_ovf       (b_ovf),
		.q_nonnull   (b_nonnull),
		.q_rows      (b_rows),
		.q_max       (b_max),
		.q_min       (b_min),
		.q_err       (b_err),
		.const_mode  (const_mode_q),
		.const_value (const_value_q),
		.pop         (q_pop),
		.done        (done),
		.sum_out     (sum_out),
		.sum_overflow(sum_overflow),
		.count_out   (count_out),
		.row_total   (row_total),
		.max_out     (max_out),
		.min_out     (min_out),
		.avg_out     (avg_out),
		.type_error  (type_error)
	);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> q_valid)
		else $error("group summary lost in queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("group summary pushed into full queue");
`endif

endmodule
